// ----- src/ile_pkg.sv -----
// Shared types and constants for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

   // List capacity and derived widths
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   // Common width for index and count compares (at least the request index width)
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   localparam int DATA_W = 32;

   // Request command codes
   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_READ   = 3'd4,
      CMD_FIND   = 3'd5
   } cmd_type;

   // Response status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Update applied by every cell of the chain
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_PUSH   = 2'd1,
      OP_INSERT = 2'd2,
      OP_REMOVE = 2'd3
   } cell_op_type;

   // Broadcast from the control to the cells
   typedef struct packed {
      cell_op_type        op;
      logic [CMP_W-1:0]   pos;
      logic [CMP_W-1:0]   fill;
      logic [DATA_W-1:0]  item;
   } cell_ctrl_type;

endpackage

// ----- src/ile_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors, compares for find.
`timescale 1ns / 1ps

module ile_cell (
   input  logic                       clock,
   input  ile_pkg::cell_ctrl_type     ctrl,
   input  logic [ile_pkg::IDX_W-1:0]  cell_idx,
   input  logic [ile_pkg::DATA_W-1:0] lower_data,
   input  logic [ile_pkg::DATA_W-1:0] upper_data,
   output logic [ile_pkg::DATA_W-1:0] data_out,
   output logic                       match
);

   logic [ile_pkg::DATA_W-1:0] data_ff;
   logic [ile_pkg::DATA_W-1:0] data_in;
   logic                       we;
   logic [ile_pkg::CMP_W-1:0]  my_idx;

   assign my_idx = ile_pkg::CMP_W'(cell_idx);

   // Pick the new content for this slot
   always_comb begin
      we      = 1'b0;
      data_in = ctrl.item;
      case (ctrl.op)
         ile_pkg::OP_PUSH: begin
            we = (my_idx == ctrl.fill);
         end
         ile_pkg::OP_INSERT: begin
            if (my_idx == ctrl.pos) begin
               we = 1'b1;
            end else if (my_idx > ctrl.pos && my_idx <= ctrl.fill) begin
               we      = 1'b1;
               data_in = lower_data;
            end
         end
         ile_pkg::OP_REMOVE: begin
            if (my_idx >= ctrl.pos && (my_idx + 1'b1) < ctrl.fill) begin
               we      = 1'b1;
               data_in = upper_data;
            end
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (we) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;
   assign match    = (my_idx < ctrl.fill) && (data_ff == ctrl.item);

endmodule

// ----- src/indexed_list_engine.sv -----
// Top level of the indexed list engine: command decode, cell chain, response register.
`timescale 1ns / 1ps

// Fixed-capacity ordered list of DEPTH (16) signed 32-bit words held in a row of
// cells, one entry per cell. For each request (push, pop, insert, remove, read, find)
// all cells shift, load or compare in parallel, and the response
// lands in an output register, so a new request is taken every cycle while the
// response side does not stall. Every response carries the count after the
// request, an empty flag and a status; a failing request leaves the list as it is.
// Reset clears the fill count and the response valid flag; no clearing pass is needed.
module indexed_list_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [4:0]         req_position_in,
   input  logic signed [31:0] req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [3:0]         rsp_found_position,
   output logic [2:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic               rsp_is_empty
);

   localparam int CW = ile_pkg::CMP_W;

   logic                        req_acc;
   logic [ile_pkg::CNT_W-1:0]   fill_ff;
   logic [ile_pkg::CNT_W-1:0]   fill_in;
   logic [CW-1:0]               fill_x;
   logic [CW-1:0]               fill_next_x;
   logic [CW-1:0]               pos_x;
   logic [CW-1:0]               rd_x;
   logic [CW-1:0]               fidx_x;
   logic                        full;
   logic                        hit;
   logic [ile_pkg::DATA_W-1:0]  rd_val;
   logic [ile_pkg::DATA_W-1:0]  value_c;
   ile_pkg::status_type         status_c;
   ile_pkg::cell_ctrl_type      ctrl;
   ile_pkg::cell_op_type        op_c;

   logic [ile_pkg::DATA_W-1:0]  cell_data [ile_pkg::DEPTH];
   logic [ile_pkg::DEPTH-1:0]   cell_match;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [31:0]                 rsp_value_ff;
   logic [3:0]                  rsp_fpos_ff;
   logic [2:0]                  rsp_status_ff;
   logic [4:0]                  rsp_count_ff;
   logic                        rsp_empty_ff;

   // Handshake: take a request whenever the response register can move
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_acc   = req_valid & ~req_stall;

   assign fill_x = CW'(fill_ff);
   assign pos_x  = CW'(req_position_in);
   assign full   = (fill_x >= CW'(ile_pkg::DEPTH));

   // Read select: pop takes the last entry, read the requested one
   assign rd_x = (req_cmd == ile_pkg::CMD_POP) ? (fill_x - 1'b1) : pos_x;

   always_comb begin
      rd_val = '0;
      for (int i = 0; i < ile_pkg::DEPTH; i++) begin
         if (CW'(i) == rd_x) begin
            rd_val = cell_data[i];
         end
      end
   end

   // Lowest matching slot
   always_comb begin
      fidx_x = '0;
      for (int i = ile_pkg::DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            fidx_x = CW'(i);
         end
      end
   end
   assign hit = |cell_match;

   // Command decode
   always_comb begin
      status_c    = ile_pkg::ST_OK;
      value_c     = '0;
      op_c        = ile_pkg::OP_HOLD;
      fill_next_x = fill_x;
      case (req_cmd)
         ile_pkg::CMD_PUSH: begin
            if (full) begin
               status_c = ile_pkg::ST_FULL;
            end else begin
               op_c        = ile_pkg::OP_PUSH;
               fill_next_x = fill_x + 1'b1;
            end
         end
         ile_pkg::CMD_POP: begin
            if (fill_x == '0) begin
               status_c = ile_pkg::ST_EMPTY;
            end else begin
               value_c     = rd_val;
               fill_next_x = fill_x - 1'b1;
            end
         end
         ile_pkg::CMD_INSERT: begin
            if (pos_x > fill_x) begin
               status_c = ile_pkg::ST_RANGE;
            end else if (full) begin
               status_c = ile_pkg::ST_FULL;
            end else begin
               op_c        = ile_pkg::OP_INSERT;
               fill_next_x = fill_x + 1'b1;
            end
         end
         ile_pkg::CMD_REMOVE: begin
            if (fill_x == '0) begin
               status_c = ile_pkg::ST_EMPTY;
            end else if (pos_x >= fill_x) begin
               status_c = ile_pkg::ST_RANGE;
            end else begin
               op_c        = ile_pkg::OP_REMOVE;
               fill_next_x = fill_x - 1'b1;
            end
         end
         ile_pkg::CMD_READ: begin
            if (fill_x == '0) begin
               status_c = ile_pkg::ST_EMPTY;
            end else if (pos_x >= fill_x) begin
               status_c = ile_pkg::ST_RANGE;
            end else begin
               value_c = rd_val;
            end
         end
         ile_pkg::CMD_FIND: begin
            if (fill_x == '0) begin
               status_c = ile_pkg::ST_EMPTY;
            end else if (!hit) begin
               status_c = ile_pkg::ST_NOTFOUND;
            end
         end
         default: begin
            status_c = ile_pkg::ST_OK;
         end
      endcase
   end

   // Broadcast to the chain; cells only move on an accepted request
   always_comb begin
      ctrl.op   = req_acc ? op_c : ile_pkg::OP_HOLD;
      ctrl.pos  = pos_x;
      ctrl.fill = fill_x;
      ctrl.item = req_item;
   end

   // Cell chain
   for (genvar g = 0; g < ile_pkg::DEPTH; g++) begin : g_cell
      logic [ile_pkg::DATA_W-1:0] lower_d;
      logic [ile_pkg::DATA_W-1:0] upper_d;
      if (g == 0) begin : g_lo_end
         assign lower_d = req_item;
      end else begin : g_lo
         assign lower_d = cell_data[g-1];
      end
      if (g == ile_pkg::DEPTH - 1) begin : g_up_end
         assign upper_d = '0;
      end else begin : g_up
         assign upper_d = cell_data[g+1];
      end
      ile_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_idx   (ile_pkg::IDX_W'(g)),
         .lower_data (lower_d),
         .upper_data (upper_d),
         .data_out   (cell_data[g]),
         .match      (cell_match[g])
      );
   end

   // Fill count
   assign fill_in = req_acc ? ile_pkg::CNT_W'(fill_next_x) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Response register
   assign rsp_valid_in = req_acc | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_value_ff  <= value_c;
         rsp_fpos_ff   <= (req_cmd == ile_pkg::CMD_FIND && status_c == ile_pkg::ST_OK) ?
                          fidx_x[3:0] : 4'd0;
         rsp_status_ff <= status_c;
         rsp_count_ff  <= fill_next_x[4:0];
         rsp_empty_ff  <= (fill_next_x == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_is_empty       = rsp_empty_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= ile_pkg::CNT_W'(ile_pkg::DEPTH))
      else $error("fill count above capacity");

   a_fill_idle: assert property (@(posedge clock) disable iff (reset)
      !req_acc |=> $stable(fill_ff))
      else $error("fill count moved without a request");

   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      req_acc && (status_c == ile_pkg::ST_FULL || status_c == ile_pkg::ST_EMPTY ||
                  status_c == ile_pkg::ST_RANGE) |=> $stable(fill_ff))
      else $error("failed request changed the fill count");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_valid && rsp_count == CW'(fill_ff) % 32)
      else $error("response count differs from fill");

endmodule
